FILE: rtl/core/wsta_pkg.sv
// Package for the weighted server task assigner core.
// Holds field widths, command codes and the controller-to-datapath command type.
// No dependencies.
package wsta_pkg;

  localparam int SEL_W       = 3;
  localparam int WEIGHT_W    = 16;
  localparam int DUR_W       = 16;
  localparam int TIME_W      = 32;
  localparam int SRV_OUT_W   = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Input item kind carried on in_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TASK = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic task_ld;  // capture a task and its base start time
    logic wt_we;    // write a server weight
    logic rd_en;    // read one server entry at the scan address
    logic pass2;    // read belongs to the selection pass
    logic fix_t;    // move start to the earliest finish if nothing was free
    logic commit;   // book the chosen server and load the result register
  } wsta_cmd_t;

endpackage

FILE: rtl/core/wsta_ctrl.sv
// Controller for the weighted server task assigner.
// Sequences the two scan passes over the server table and owns result valid.
// Depends on wsta_pkg.
module wsta_ctrl
  import wsta_pkg::*;
#(
  parameter int NUM_SERVERS = 8,
  parameter int IDX_W       = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_cmd,
  output logic             in_tready,
  input  logic             out_tready,
  output logic             out_valid,
  output wsta_cmd_t        cmd,
  output logic [IDX_W-1:0] rd_addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_FIX,
    S_SCAN2,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             cnt_last;

  assign cnt_last  = (cnt_r == IDX_W'(NUM_SERVERS - 1));
  assign in_tready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign rd_addr   = cnt_r;

  always_comb begin
    cmd         = '0;
    cmd.task_ld = (state_r == S_IDLE) && in_tvalid && (in_cmd == CMD_TASK);
    cmd.wt_we   = (state_r == S_IDLE) && in_tvalid && (in_cmd == CMD_LOAD);
    cmd.rd_en   = (state_r == S_SCAN1) || (state_r == S_SCAN2);
    cmd.pass2   = (state_r == S_SCAN2);
    cmd.fix_t   = (state_r == S_SCAN2) && (cnt_r == '0);
    cmd.commit  = (state_r == S_COMMIT) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (cmd.task_ld) begin
            state_r <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (cnt_last) begin
            cnt_r   <= '0;
            state_r <= S_FIX;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FIX: begin
          state_r <= S_SCAN2;
        end
        S_SCAN2: begin
          if (cnt_last) begin
            cnt_r   <= '0;
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (cmd.commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("commit while the result register still holds an untaken result");

  a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state_r == S_IDLE && out_valid_r))
    else $error("commit did not return to idle with a valid result");

  a_task_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_cmd == CMD_TASK) |=> (state_r == S_SCAN1 && cnt_r == '0))
    else $error("accepted task did not start the first scan at server zero");
`endif

endmodule

FILE: rtl/core/wsta_dp.sv
// Datapath for the weighted server task assigner.
// Holds the weight and finish-time tables, the scan compare stage and the result register.
// Depends on wsta_pkg.
module wsta_dp
  import wsta_pkg::*;
#(
  parameter int NUM_SERVERS = 8,
  parameter int IDX_W       = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsta_cmd_t            cmd,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [SEL_W-1:0]     in_server_sel,
  input  logic [WEIGHT_W-1:0]  in_weight,
  input  logic [DUR_W-1:0]     in_duration,
  output logic [SRV_OUT_W-1:0] out_server,
  output logic [TIME_W-1:0]    out_start
);

  localparam int SEL_CMP_W = 7;

  logic [WEIGHT_W-1:0]  wt_mem [NUM_SERVERS];
  logic [TIME_W-1:0]    bu_mem [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] bu_vld_r;

  logic [TIME_W-1:0]    arrival_r;
  logic [TIME_W-1:0]    prev_start_r;
  logic [TIME_W-1:0]    t_r;
  logic [DUR_W-1:0]     dur_r;
  logic [TIME_W-1:0]    earliest_r;
  logic                 any_free_r;
  logic                 best_found_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [WEIGHT_W-1:0]  best_w_r;

  logic                 stg_vld_r;
  logic                 stg_pass2_r;
  logic [IDX_W-1:0]     stg_idx_r;
  logic [TIME_W-1:0]    bu_rd_r;
  logic                 bu_rd_vld_r;
  logic [WEIGHT_W-1:0]  wt_rd_r;

  logic [SRV_OUT_W-1:0] out_server_r;
  logic [TIME_W-1:0]    out_start_r;

  logic [TIME_W-1:0]    busy_eff;
  logic                 is_free;
  logic [TIME_W-1:0]    t_base;
  logic                 sel_in_range;

  assign busy_eff     = bu_rd_vld_r ? bu_rd_r : '0;
  assign is_free      = (busy_eff <= t_r);
  assign t_base       = (prev_start_r > arrival_r) ? prev_start_r : arrival_r;
  assign sel_in_range = (SEL_CMP_W'(in_server_sel) < SEL_CMP_W'(NUM_SERVERS));
  assign out_server   = out_server_r;
  assign out_start    = out_start_r;

  // Tables: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wt_we && sel_in_range) begin
      wt_mem[IDX_W'(in_server_sel)] <= in_weight;
    end
    if (cmd.commit) begin
      bu_mem[best_idx_r] <= t_r + TIME_W'(dur_r);
    end
    if (cmd.rd_en) begin
      bu_rd_r <= bu_mem[rd_addr];
      wt_rd_r <= wt_mem[rd_addr];
    end
  end

  // Control state of the datapath: valid bits, time counters, compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bu_vld_r     <= '0;
      arrival_r    <= '0;
      prev_start_r <= '0;
      stg_vld_r    <= 1'b0;
      any_free_r   <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      stg_vld_r <= cmd.rd_en;
      if (cmd.task_ld) begin
        any_free_r   <= 1'b0;
        best_found_r <= 1'b0;
      end
      if (stg_vld_r && !stg_pass2_r && is_free) begin
        any_free_r <= 1'b1;
      end
      if (stg_vld_r && stg_pass2_r && is_free &&
          (!best_found_r || wt_rd_r < best_w_r)) begin
        best_found_r <= 1'b1;
      end
      if (cmd.commit) begin
        bu_vld_r[best_idx_r] <= 1'b1;
        prev_start_r         <= t_r;
        arrival_r            <= arrival_r + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    stg_pass2_r <= cmd.pass2;
    stg_idx_r   <= rd_addr;
    if (cmd.rd_en) begin
      bu_rd_vld_r <= bu_vld_r[rd_addr];
    end
    if (cmd.task_ld) begin
      t_r   <= t_base;
      dur_r <= in_duration;
    end else if (cmd.fix_t && !any_free_r) begin
      t_r <= earliest_r;
    end
    if (stg_vld_r && !stg_pass2_r) begin
      if (stg_idx_r == '0 || busy_eff < earliest_r) begin
        earliest_r <= busy_eff;
      end
    end
    if (stg_vld_r && stg_pass2_r && is_free &&
        (!best_found_r || wt_rd_r < best_w_r)) begin
      best_idx_r <= stg_idx_r;
      best_w_r   <= wt_rd_r;
    end
    if (cmd.commit) begin
      out_server_r <= SRV_OUT_W'(best_idx_r);
      out_start_r  <= t_r;
    end
  end

`ifndef ASSERT_OFF
  a_commit_has_server: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> best_found_r)
    else $error("commit without any server free at the start time");
`endif

endmodule

FILE: rtl/core/weighted_server_task_assigner_core.sv
// Weighted server task assigner core: a weight load gives no result.
// A task holds off the input until its result is committed: out_tvalid rises after two
// one-entry-per-cycle scans of the finish-time table (earliest finish, then lightest free
// server) plus fix, drain and commit; commit waits while an untaken result is held.
// Synchronous active-low reset frees all servers at once (valid bits), zeroes the time
// counters and drops out_tvalid; weights are undefined until loaded. No clearing pass.
module weighted_server_task_assigner_core
  import wsta_pkg::*;
#(
  parameter int NUM_SERVERS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] server_sel, [18:3] weight,
                                             // [34:19] duration, [39:35] zero
  input  logic                   in_tuser,   // [0] cmd: 0 load weight, 1 submit task
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [2:0] assigned_server, [34:3] start_time,
                                             // [39:35] zero
);

  // Server index width; a pool of one still uses one bit
  localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  wsta_cmd_t            cmd;
  logic [IDX_W-1:0]     rd_addr;
  logic [SRV_OUT_W-1:0] out_server;
  logic [TIME_W-1:0]    out_start;

  // Controller: accepts an item only when idle, steps both scans, commits the result
  // once the output register is free or being drained in the same cycle.
  wsta_ctrl #(
    .NUM_SERVERS (NUM_SERVERS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .cmd        (cmd),
    .rd_addr    (rd_addr)
  );

  // Datapath: weight and finish-time tables, compare stage, start-time tracking,
  // and the result register that holds a result until its transfer.
  wsta_dp #(
    .NUM_SERVERS (NUM_SERVERS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .in_server_sel (in_tdata[2:0]),
    .in_weight     (in_tdata[18:3]),
    .in_duration   (in_tdata[34:19]),
    .out_server    (out_server),
    .out_start     (out_start)
  );

  // Pack the result, zero fill to whole bytes
  assign out_tdata = {(OUT_TDATA_W - SRV_OUT_W - TIME_W)'(0), out_start, out_server};

endmodule

FILE: dv/weighted_server_task_assigner_core_tb.sv
// Self-checking testbench for weighted_server_task_assigner_core.
// Predicts server placement and start time per task and checks every result transfer.
// Depends on wsta_pkg and the core RTL only.
module weighted_server_task_assigner_core_tb;
  import wsta_pkg::*;

  localparam int SERVERS      = 8;
  localparam int ITEMS        = 1250;
  localparam int STALL_LIMIT  = 4000;            // cycles without any transfer
  localparam int DRAIN_CYCLES = 2*SERVERS + 24;  // task latency plus margin
  localparam int PAD_W        = IN_TDATA_W - SEL_W - WEIGHT_W - DUR_W;

  // One predicted task placement, as carried on out_tdata.
  typedef struct packed {
    logic [SRV_OUT_W-1:0] server;
    logic [TIME_W-1:0]    start;
  } placement_t;

  // Scoreboard: keeps its own copy of the server pool and the queue of
  // placements still owed by the block.
  class placement_board;
    logic [WEIGHT_W-1:0] weight_of [SERVERS];
    logic [TIME_W-1:0]   free_at [SERVERS];
    logic [TIME_W-1:0]   arrivals;
    logic [TIME_W-1:0]   last_start;
    placement_t          due[$];
    int                  fails, loads, tasks, waited, checked;

    function new();
      foreach (free_at[i]) begin
        free_at[i]   = '0;
        weight_of[i] = '0;
      end
      arrivals   = '0;
      last_start = '0;
    endfunction

    // Apply one accepted input transfer to the pool; a task also queues its placement.
    function void note_item(logic cmd, logic [SEL_W-1:0] sel, logic [WEIGHT_W-1:0] wt,
                            logic [DUR_W-1:0] dur);
      logic [TIME_W-1:0] start_t;
      logic [TIME_W-1:0] soonest;
      bit                any_free;
      int                pick;
      placement_t        owed;
      if (cmd == CMD_LOAD) begin
        weight_of[sel] = wt;
        loads++;
        return;
      end
      tasks++;
      start_t  = (last_start > arrivals) ? last_start : arrivals;
      soonest  = free_at[0];
      any_free = 1'b0;
      for (int i = 0; i < SERVERS; i++) begin
        if (free_at[i] <= start_t) any_free = 1'b1;
        if (free_at[i] < soonest) soonest = free_at[i];
      end
      // Nothing free yet: slide the start to the earliest finish.
      if (!any_free) begin
        start_t = soonest;
        waited++;
      end
      pick = -1;
      for (int i = 0; i < SERVERS; i++) begin
        if (free_at[i] <= start_t && (pick < 0 || weight_of[i] < weight_of[pick])) pick = i;
      end
      free_at[pick] = start_t + TIME_W'(dur);
      last_start    = start_t;
      arrivals      = arrivals + 1'b1;
      owed.server   = SRV_OUT_W'(pick);
      owed.start    = start_t;
      due.insert(due.size(), owed);
    endfunction

    task report(string what);
      fails++;
      $display("[%0t] placement error: %s", $time, what);
    endtask

    // Compare one result transfer against the oldest owed placement.
    task check_placement(logic [OUT_TDATA_W-1:0] word);
      placement_t got;
      placement_t want;
      got.server = word[SRV_OUT_W-1:0];
      got.start  = word[SRV_OUT_W +: TIME_W];
      checked++;
      if (due.size() == 0) begin
        report($sformatf("unrequested result: server %0d start %0d", got.server, got.start));
        return;
      end
      want = due.pop_front();
      if (got.server !== want.server)
        report($sformatf("server: got %0d, want %0d", got.server, want.server));
      if (got.start !== want.start)
        report($sformatf("start time: got %0d, want %0d", got.start, want.start));
      if (word[OUT_TDATA_W-1:SRV_OUT_W+TIME_W] !== '0)
        report($sformatf("pad bits not zero: %h", word));
    endtask

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  placement_board board = new();

  // Idle modes; when quick, that side never inserts wait cycles.
  bit sender_quick   = 1'b0;
  bit receiver_quick = 1'b0;
  int quiet          = 0;

  weighted_server_task_assigner_core #(
    .NUM_SERVERS(SERVERS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Send one item. Call at a falling edge; returns at the falling edge after
  // the transfer. Valid stays high into the next item when it has no gap.
  task automatic send_item(input logic cmd, input logic [SEL_W-1:0] sel,
                           input logic [WEIGHT_W-1:0] wt, input logic [DUR_W-1:0] dur);
    int gap;
    gap = sender_quick ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {{PAD_W{1'b0}}, dur, wt, sel};
    do @(posedge clk); while (!in_tready);
    board.note_item(cmd, sel, wt, dur);
    @(negedge clk);
  endtask

  // Hold the sender off until every owed placement has come back.
  task automatic hold_for_results();
    in_tvalid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Result side: draw a stall per result, then take the next transfer.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = receiver_quick ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_placement(out_tdata);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("weighted_server_task_assigner_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int               r;
    bit               long_ok;
    logic [DUR_W-1:0] dur;
    logic [WEIGHT_W-1:0] wt;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = CMD_LOAD;
    in_tdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: load every weight before the first task, with ties and both
    // weight extremes; unused duration bits swing between all-ones and zero.
    send_item(CMD_LOAD, 3'd0, 16'd5,    16'hFFFF);
    send_item(CMD_LOAD, 3'd1, 16'd5,    16'h0000);  // tie with server 0
    send_item(CMD_LOAD, 3'd2, 16'hFFFF, 16'hFFFF);
    send_item(CMD_LOAD, 3'd3, 16'h0000, 16'h0000);
    send_item(CMD_LOAD, 3'd4, 16'h8000, 16'hFFFF);
    send_item(CMD_LOAD, 3'd5, 16'h7FFF, 16'h0000);
    send_item(CMD_LOAD, 3'd6, 16'h0000, 16'hFFFF);  // tie with server 3
    send_item(CMD_LOAD, 3'd7, 16'h0001, 16'h0000);
    // Shortest and longest durations, then a zero-length task that frees its
    // server at its own start.
    send_item(CMD_TASK, 3'd7, 16'hFFFF, 16'd1);
    send_item(CMD_TASK, 3'd0, 16'h0000, 16'hFFFF);
    send_item(CMD_TASK, 3'd7, 16'hFFFF, 16'd0);
    send_item(CMD_TASK, 3'd0, 16'h0000, 16'd3);
    // Reload a weight while work is in flight.
    send_item(CMD_LOAD, 3'd7, 16'h0000, 16'hAAAA);
    // Fill every server, then force starts at the earliest finish time.
    repeat (8) send_item(CMD_TASK, 3'd5, 16'h5555, 16'hFFFF);
    send_item(CMD_TASK, 3'd2, 16'hAAAA, 16'd1);
    send_item(CMD_TASK, 3'd5, 16'h5555, 16'd2);
    hold_for_results();

    // Random: mostly tasks, some weight reloads; switch idle modes and the
    // duration mix in stretches so gaps land on every phase of a task.
    long_ok = 1'b1;
    while (board.loads + board.tasks < ITEMS) begin
      if ((board.loads + board.tasks) % 150 == 0) begin
        sender_quick   = ($urandom_range(0, 3) == 0);
        receiver_quick = ($urandom_range(0, 3) == 0);
        long_ok        = ($urandom_range(0, 2) != 0);
      end
      if ((board.loads + board.tasks) == ITEMS / 2 || $urandom_range(0, 199) == 0)
        hold_for_results();
      if ($urandom_range(0, 99) < 12) begin
        r = $urandom_range(0, 9);
        if (r < 5)      wt = WEIGHT_W'($urandom);
        else if (r < 8) wt = WEIGHT_W'($urandom_range(0, 3));  // provoke ties
        else            wt = (r == 8) ? '0 : '1;
        send_item(CMD_LOAD, SEL_W'($urandom), wt, DUR_W'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45)      dur = DUR_W'($urandom_range(1, 12));
        else if (r < 75) dur = DUR_W'($urandom_range(1, 300));
        else if (r < 95) dur = DUR_W'(long_ok ? $urandom_range(1, 65535) : $urandom_range(1, 40));
        else             dur = (r < 98) ? DUR_W'(1) : '1;
        send_item(CMD_TASK, SEL_W'($urandom), WEIGHT_W'($urandom), dur);
      end
    end

    // Drain: wait for every owed result, then watch for strays.
    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d placements never arrived", board.pending()));
    $display("run covered %0d weight loads and %0d tasks, %0d results checked",
             board.loads, board.tasks, board.checked);
    $display("%0d tasks found every server busy and waited for the earliest finish",
             board.waited);
    if (board.fails == 0) begin
      $display("weighted_server_task_assigner_core: match");
    end else begin
      $display("weighted_server_task_assigner_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/wsta_pkg.sv
rtl/core/wsta_ctrl.sv
rtl/core/wsta_dp.sv
rtl/core/weighted_server_task_assigner_core.sv
dv/weighted_server_task_assigner_core_tb.sv
